/* hw/rtl/tsb_pkg.sv */
// tsb_pkg: shared types, header constants and sizes for the TCP SYN packet builder.
// No dependencies; used by every module under hw/rtl.
package tsb_pkg;

  // Option area size, clamped to the supported range
  localparam int OPTION_BYTES = 20;
  localparam int OPT_LEN   = (OPTION_BYTES < 8) ? 8 : ((OPTION_BYTES > 40) ? 40 : OPTION_BYTES);
  localparam int IP_LEN    = 20;
  localparam int TCP_LEN   = 20 + OPT_LEN;
  localparam int PKT_LEN   = IP_LEN + TCP_LEN;
  localparam int MAX_WORDS = 15;
  localparam int PKT_WORDS = ((PKT_LEN + 3) / 4 > MAX_WORDS) ? MAX_WORDS : (PKT_LEN + 3) / 4;

  localparam logic [15:0] PKT_LEN16   = 16'(PKT_LEN);
  localparam logic [15:0] TCP_LEN16   = 16'(TCP_LEN);
  localparam logic [3:0]  LAST_IDX    = 4'(PKT_WORDS - 1);
  localparam logic [3:0]  DATA_OFFSET = 4'((TCP_LEN + 3) / 4);

  // Fixed header bytes
  localparam logic [7:0]  IP_VER_IHL    = 8'h45;
  localparam logic [7:0]  PROTO_TCP     = 8'h06;
  localparam logic [7:0]  FLAG_SYN      = 8'h02;
  localparam logic [7:0]  OPT_KIND_MSS  = 8'h02;
  localparam logic [7:0]  OPT_SIZE_MSS  = 8'h04;
  localparam logic [7:0]  OPT_KIND_SACK = 8'h04;
  localparam logic [7:0]  OPT_SIZE_SACK = 8'h02;

  // Request kinds
  localparam logic ACTION_SYN       = 1'b0;
  localparam logic ACTION_KEEPALIVE = 1'b1;

  // Register indexes and reset values
  localparam logic        REG_WINDOW = 1'b0;
  localparam logic        REG_MSS    = 1'b1;
  localparam logic [15:0] WINDOW_RST = 16'd5840;
  localparam logic [15:0] MSS_RST    = 16'd48;

  typedef struct packed {
    logic        action;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  time_to_live;
    logic [15:0] ip_ident;
    logic [31:0] seq_number;
  } tsb_in_t;

  typedef struct packed {
    logic [31:0] packet_word;
    logic [3:0]  word_index;
    logic        last_word;
  } tsb_out_t;

  typedef struct packed {
    logic [15:0] window_size;
    logic [15:0] mss_value;
  } tsb_cfg_t;

  // Request plus everything needed to emit its words
  typedef struct packed {
    tsb_in_t     req;
    tsb_cfg_t    cfg;
    logic [15:0] ip_csum;
    logic [15:0] tcp_csum;
  } tsb_hdr_t;

endpackage

/* hw/rtl/tsb_cfg_regs.sv */
// tsb_cfg_regs: APB-style register file holding window size and MSS.
// Depends on tsb_pkg.
module tsb_cfg_regs (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output tsb_pkg::tsb_cfg_t cfg
);

  logic [15:0] window_r;
  logic [15:0] mss_r;
  logic        wr_en;
  logic        reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[2];

  // Register writes on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= tsb_pkg::WINDOW_RST;
      mss_r    <= tsb_pkg::MSS_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        tsb_pkg::REG_WINDOW: window_r <= pwdata[15:0];
        tsb_pkg::REG_MSS:    mss_r    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_sel)
      tsb_pkg::REG_WINDOW: prdata = {16'h0000, window_r};
      tsb_pkg::REG_MSS:    prdata = {16'h0000, mss_r};
      default:             prdata = 32'h0000_0000;
    endcase
  end

  assign cfg.window_size = window_r;
  assign cfg.mss_value   = mss_r;

endmodule

/* hw/rtl/tsb_csum_pipe.sv */
// tsb_csum_pipe: three-stage elastic pipeline computing IP and TCP checksums.
// Depends on tsb_pkg.
module tsb_csum_pipe (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tsb_pkg::tsb_in_t   in_data,
  input  tsb_pkg::tsb_cfg_t  cfg,
  output logic               dn_valid,
  input  logic               dn_ready,
  output tsb_pkg::tsb_hdr_t  dn_data
);

  // Stage registers
  logic              v1_r, v2_r, v3_r;
  logic              v1_nxt, v2_nxt, v3_nxt;
  tsb_pkg::tsb_hdr_t h1_r, h2_r, h3_r;
  logic [17:0]       ip_part_r, addr_part_r, tcp_part_r;
  logic [18:0]       tcp_fix_r;
  logic [18:0]       ip_sum_r;
  logic [19:0]       tcp_sum_r;
  logic              rdy1, rdy2, rdy3;

  // Stage 1 partial sums
  logic              is_syn;
  logic [17:0]       ip_part;
  logic [17:0]       addr_part;
  logic [17:0]       tcp_part;
  logic [18:0]       tcp_fix;
  logic [18:0]       opt_sum;
  logic [7:0]        flags;

  // Fold to 16 bits and complement
  function automatic logic [15:0] fold_not(input logic [19:0] x);
    logic [16:0] f1;
    logic [15:0] f2;
    f1 = {1'b0, x[15:0]} + {13'd0, x[19:16]};
    f2 = f1[15:0] + {15'd0, f1[16]};
    return ~f2;
  endfunction

  assign rdy3     = !v3_r | dn_ready;
  assign rdy2     = !v2_r | rdy3;
  assign rdy1     = !v1_r | rdy2;
  assign in_ready = rdy1;

  assign v1_nxt = rdy1 ? in_valid : v1_r;
  assign v2_nxt = rdy2 ? v1_r : v2_r;
  assign v3_nxt = rdy3 ? v2_r : v3_r;

  always_comb begin
    is_syn  = (in_data.action == tsb_pkg::ACTION_SYN);
    flags   = is_syn ? tsb_pkg::FLAG_SYN : 8'h00;
    ip_part = {2'b00, tsb_pkg::IP_VER_IHL, 8'h00} + {2'b00, tsb_pkg::PKT_LEN16}
            + {2'b00, in_data.time_to_live, tsb_pkg::PROTO_TCP}
            + {2'b00, in_data.ip_ident};
    addr_part = {2'b00, in_data.src_addr[31:16]} + {2'b00, in_data.src_addr[15:0]}
              + {2'b00, in_data.dst_addr[31:16]} + {2'b00, in_data.dst_addr[15:0]};
    tcp_part  = {2'b00, in_data.src_port} + {2'b00, in_data.dst_port}
              + {2'b00, in_data.seq_number[31:16]} + {2'b00, in_data.seq_number[15:0]};
    opt_sum   = is_syn ? ({3'd0, tsb_pkg::OPT_KIND_MSS, tsb_pkg::OPT_SIZE_MSS}
                        + {3'd0, cfg.mss_value}
                        + {3'd0, tsb_pkg::OPT_KIND_SACK, tsb_pkg::OPT_SIZE_SACK})
                     : 19'd0;
    tcp_fix   = {11'd0, tsb_pkg::PROTO_TCP} + {3'd0, tsb_pkg::TCP_LEN16}
              + {3'd0, tsb_pkg::DATA_OFFSET, 4'h0, flags}
              + {3'd0, cfg.window_size} + opt_sum;
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Stage 1: capture request and partial sums
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      h1_r.req      <= in_data;
      h1_r.cfg      <= cfg;
      h1_r.ip_csum  <= 16'h0000;
      h1_r.tcp_csum <= 16'h0000;
      ip_part_r     <= ip_part;
      addr_part_r   <= addr_part;
      tcp_part_r    <= tcp_part;
      tcp_fix_r     <= tcp_fix;
    end
  end

  // Stage 2: full IP and TCP sum accumulations
  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      h2_r      <= h1_r;
      ip_sum_r  <= {1'b0, ip_part_r} + {1'b0, addr_part_r};
      tcp_sum_r <= {2'b00, addr_part_r} + {2'b00, tcp_part_r} + {1'b0, tcp_fix_r};
    end
  end

  // Stage 3: end-around carry fold and complement
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      h3_r.req      <= h2_r.req;
      h3_r.cfg      <= h2_r.cfg;
      h3_r.ip_csum  <= fold_not({1'b0, ip_sum_r});
      h3_r.tcp_csum <= fold_not(tcp_sum_r);
    end
  end

  assign dn_valid = v3_r;
  assign dn_data  = h3_r;

`ifndef ASSERT_OFF
  // A stalled stage-3 item stays and keeps its checksums
  a_hold3: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !dn_ready |=> v3_r && $stable(h3_r.tcp_csum) && $stable(h3_r.ip_csum))
    else $error("stage 3 item changed while stalled");
  // Stage 2 never overwrites while stage 3 is blocked and full
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && v3_r && !dn_ready |=> v2_r)
    else $error("stage 2 item lost during stall");
  // Nothing appears at stage 3 without an item in stage 2
  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    !v3_r && !v2_r |=> !v3_r)
    else $error("stage 3 became valid from nothing");
`endif

endmodule

/* hw/rtl/tsb_serializer.sv */
// tsb_serializer: holds one finished header and sends it as 32-bit beats.
// Depends on tsb_pkg.
module tsb_serializer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  tsb_pkg::tsb_hdr_t up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsb_pkg::tsb_out_t out_data
);

  tsb_pkg::tsb_hdr_t hold_r;
  logic              busy_r, busy_nxt;
  logic [3:0]        idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  tsb_pkg::tsb_out_t out_r;
  logic              emit;
  logic              last_emit;
  logic              load;
  logic              is_syn;
  logic [31:0]       word;

  assign emit      = busy_r & (!out_valid_r | out_ready);
  assign last_emit = emit & (idx_r == tsb_pkg::LAST_IDX);
  assign up_ready  = !busy_r | last_emit;
  assign load      = up_valid & up_ready;

  assign busy_nxt      = load ? 1'b1 : (last_emit ? 1'b0 : busy_r);
  assign idx_nxt       = load ? 4'd0 : (emit ? idx_r + 4'd1 : idx_r);
  assign out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // Word select by position in the header
  always_comb begin
    is_syn = (hold_r.req.action == tsb_pkg::ACTION_SYN);
    case (idx_r)
      4'd0:  word = {tsb_pkg::IP_VER_IHL, 8'h00, tsb_pkg::PKT_LEN16};
      4'd1:  word = {hold_r.req.ip_ident, 16'h0000};
      4'd2:  word = {hold_r.req.time_to_live, tsb_pkg::PROTO_TCP, hold_r.ip_csum};
      4'd3:  word = hold_r.req.src_addr;
      4'd4:  word = hold_r.req.dst_addr;
      4'd5:  word = {hold_r.req.src_port, hold_r.req.dst_port};
      4'd6:  word = hold_r.req.seq_number;
      4'd8:  word = {tsb_pkg::DATA_OFFSET, 4'h0, (is_syn ? tsb_pkg::FLAG_SYN : 8'h00),
                     hold_r.cfg.window_size};
      4'd9:  word = {hold_r.tcp_csum, 16'h0000};
      4'd10: word = is_syn ? {tsb_pkg::OPT_KIND_MSS, tsb_pkg::OPT_SIZE_MSS,
                              hold_r.cfg.mss_value} : 32'h0000_0000;
      4'd11: word = is_syn ? {tsb_pkg::OPT_KIND_SACK, tsb_pkg::OPT_SIZE_SACK, 16'h0000}
                           : 32'h0000_0000;
      default: word = 32'h0000_0000;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: held header and output beat
  always_ff @(posedge clk) begin
    if (load) begin
      hold_r <= up_data;
    end
    if (emit) begin
      out_r.packet_word <= word;
      out_r.word_index  <= idx_r;
      out_r.last_word   <= (idx_r == tsb_pkg::LAST_IDX);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  // Last flag marks exactly the final position
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.last_word == (out_r.word_index == tsb_pkg::LAST_IDX)))
    else $error("last_word does not match word_index");
  // Words of one header follow with no gap
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_r.last_word |=> out_valid_r)
    else $error("gap inside a header");
  // Index advances by one within a header
  a_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ready && !out_r.last_word |=>
      out_r.word_index == $past(out_r.word_index) + 4'd1)
    else $error("word_index skipped or repeated");
  // A new header is taken only when not mid-header
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy_r || (idx_r == tsb_pkg::LAST_IDX))
    else $error("header replaced before all words sent");
`endif

endmodule

/* hw/rtl/tcp_syn_packet_builder.sv */
// tcp_syn_packet_builder: top level of the IPv4 + TCP SYN/keepalive header builder.
// Depends on tsb_pkg, tsb_cfg_regs, tsb_csum_pipe and tsb_serializer.
//
//  channel  | handshake              | payload
//  ---------+------------------------+----------------------------------------
//  in_      | in_valid / in_ready    | tsb_in_t: one header request per beat
//  out_     | out_valid / out_ready  | tsb_out_t: one 32-bit header word per beat
//  cfg_     | APB psel/penable/pwrite| window_size @0x0, mss_value @0x4
//
// Each request yields fifteen output beats, one per cycle while out_ready is high,
// so the sustained request rate is set by the output word port. A request passes
// through three checksum stages, the header hold register and the output register
// before its first word appears. Requests queue in the checksum stages while a
// header is being sent. Synchronous active-low reset empties all stages;
// stalls on either side hold every item in place.
module tcp_syn_packet_builder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsb_pkg::tsb_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output tsb_pkg::tsb_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  tsb_pkg::tsb_cfg_t cfg;
  tsb_pkg::tsb_hdr_t hdr;
  logic              hdr_valid;
  logic              hdr_ready;

  // Configuration registers
  tsb_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Checksum pipeline
  tsb_csum_pipe u_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .dn_valid (hdr_valid),
    .dn_ready (hdr_ready),
    .dn_data  (hdr)
  );

  // Word serializer
  tsb_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (hdr_valid),
    .up_ready  (hdr_ready),
    .up_data   (hdr),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
